@@ src/assert_macros.svh @@
// Assertion macros shared by the engine RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ src/tce_pkg.sv @@
// Types and constants of the TCP connection engine.
// Depends on nothing; used by tce_ctrl, tce_datapath and the top level.
package tce_pkg;
   localparam logic [2:0] ST_CLOSED = 3'd0;
   localparam logic [2:0] ST_LISTEN = 3'd1;
   localparam logic [2:0] ST_SYN_SENT = 3'd2;
   localparam logic [2:0] ST_SYN_RCVD = 3'd3;
   localparam logic [2:0] ST_ESTAB = 3'd4;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_ACK = 8'h10;
   localparam logic [7:0] FL_SYNACK = 8'h12;
   localparam logic [7:0] FL_FINACK = 8'h11;

   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_HTTP = 2'd1;
   localparam logic [1:0] EV_MQTT = 2'd2;
   localparam logic [1:0] EV_MQTT_CONN = 2'd3;

   localparam logic [1:0] REG_HTTP_PORT = 2'd0;
   localparam logic [1:0] REG_MQTT_REMOTE = 2'd1;
   localparam logic [1:0] REG_MQTT_LOCAL = 2'd2;
   localparam logic [1:0] REG_SERVER_SEQ = 2'd3;

   localparam logic [15:0] RST_HTTP_PORT = 16'd80;
   localparam logic [15:0] RST_MQTT_REMOTE = 16'd1883;
   localparam logic [15:0] RST_MQTT_LOCAL = 16'd18830;
   localparam logic [31:0] RST_SERVER_SEQ = 32'h11223344;

   typedef enum logic [2:0] {
      CT_IDLE, CT_LOOKUP, CT_EXEC, CT_EMIT, CT_WAIT
   } ctrl_state_type;

   typedef struct packed {
      logic kind;           // 0 send, 1 event
      logic [7:0] flags;
      logic [1:0] event_code;
   } result_slot_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
      logic load_out;
      logic [1:0] out_idx;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_open;
      logic found;
      logic [1:0] count;
   } dp_status_type;
endpackage

@@ src/tce_stream_if.sv @@
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface tce_stream_if #(parameter int WIDTH = 8);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/tcp_connection_engine.sv @@
// Top level of the TCP connection engine: channels, controller, datapath.
// Depends on tce_pkg, tce_stream_if, tce_ctrl, tce_datapath, assert_macros.svh.
//
// channel  direction  contents
// req      in         parsed segment or open-slot command
// rsp      out        send request or application event, last marks the end
// csr      in         register write, index and data
//
// A request passes through capture, slot lookup and state update; open
// commands and segments that match no slot end there. A matched segment
// then loads and hands off each result in turn, the handoff waiting while
// rsp.ready stays low, and a last check returns the engine to idle.
// Reset is synchronous; slot 0 comes up listening on port 80.
// A stalled result holds the engine; no request is taken until all go out.
`include "assert_macros.svh"
module tcp_connection_engine #(
   parameter int NUM_SLOTS = 4
) (
   input  logic clock,
   input  logic reset,
   tce_stream_if.sink req,
   tce_stream_if.source rsp,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   tce_pkg::dp_cmd_type cmd;
   tce_pkg::dp_status_type status;
   logic [132:0] out_data;
   logic out_last;

   tce_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_last(out_last),
      .cmd(cmd), .status(status)
   );

   tce_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .in_data(req.data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status), .out_data(out_data)
   );

   assign rsp.data = {out_data[132:1], out_last};

   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
   `ASSERT_IMPL(a_count, clock, reset, rsp.valid, status.count != 2'd0)
endmodule

@@ src/tce_ctrl.sv @@
// Controller of the TCP connection engine: sequences each request.
// Depends on tce_pkg.
module tce_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic out_last,
   output tce_pkg::dp_cmd_type cmd,
   input  tce_pkg::dp_status_type status
);
   tce_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tce_pkg::CT_IDLE;
         idx_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      case (state_ff)
         tce_pkg::CT_IDLE: begin
            if (in_valid) state_in = tce_pkg::CT_LOOKUP;
         end
         tce_pkg::CT_LOOKUP: state_in = tce_pkg::CT_EXEC;
         tce_pkg::CT_EXEC: begin
            idx_in = 2'd0;
            if (status.is_open || !status.found) state_in = tce_pkg::CT_IDLE;
            else state_in = tce_pkg::CT_EMIT;
         end
         tce_pkg::CT_EMIT: begin
            if (idx_ff >= status.count) state_in = tce_pkg::CT_IDLE;
            else state_in = tce_pkg::CT_WAIT;
         end
         tce_pkg::CT_WAIT: begin
            if (out_ready) begin
               idx_in = idx_ff + 2'd1;
               state_in = tce_pkg::CT_EMIT;
            end
         end
         default: state_in = tce_pkg::CT_IDLE;
      endcase
   end

   always_comb begin
      in_ready = (state_ff == tce_pkg::CT_IDLE);
      out_valid = (state_ff == tce_pkg::CT_WAIT);
      out_last = (idx_ff + 2'd1 == status.count);
      cmd.capture = in_ready && in_valid;
      cmd.lookup = (state_ff == tce_pkg::CT_LOOKUP);
      cmd.execute = (state_ff == tce_pkg::CT_EXEC);
      cmd.load_out = (state_ff == tce_pkg::CT_EMIT) && (idx_ff < status.count);
      cmd.out_idx = idx_ff;
   end
endmodule

@@ src/tce_datapath.sv @@
// Datapath: slot table, lookup, state update and result formatting.
// Depends on tce_pkg.
module tce_datapath #(
   parameter int NUM_SLOTS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic [131:0] in_data,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data,
   input  tce_pkg::dp_cmd_type cmd,
   output tce_pkg::dp_status_type status,
   output logic [132:0] out_data
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [15:0] http_ff, mqr_ff, mql_ff;
   logic [31:0] iseq_ff;

   logic act_ff [NUM_SLOTS];
   logic [15:0] lport_ff [NUM_SLOTS];
   logic [15:0] rport_ff [NUM_SLOTS];
   logic [2:0] cst_ff [NUM_SLOTS];
   logic [31:0] sseq_ff [NUM_SLOTS];
   logic [31:0] rack_ff [NUM_SLOTS];

   logic [131:0] req_ff;
   logic found_ff, found_in;
   logic [SW-1:0] hit_ff, hit_in;
   logic [1:0] cnt_ff;
   tce_pkg::result_slot_type res_ff [3];
   logic [31:0] o_seq_ff [3];
   logic [31:0] o_ack_ff [3];
   logic [15:0] plen_ff;
   logic [6:0] poff_ff;
   logic [15:0] slp_ff, srp_ff;
   logic [132:0] out_ff;

   // request fields
   logic func, omode;
   logic [3:0] iphw, tcpw;
   logic [15:0] tot, sport, dport;
   logic [31:0] rseq, rack;
   logic [7:0] fl;
   logic [1:0] oslot;
   assign {func, iphw, tot, tcpw, sport, dport, rseq, rack, fl, oslot, omode} = req_ff;

   // lookup: connected match first, then a listener
   always_comb begin
      found_in = 1'b0;
      hit_in = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (act_ff[i] && lport_ff[i] == dport && cst_ff[i] == tce_pkg::ST_LISTEN) begin
            found_in = 1'b1;
            hit_in = SW'(i);
         end
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (act_ff[i] && lport_ff[i] == dport && cst_ff[i] != tce_pkg::ST_LISTEN
             && rport_ff[i] == sport) begin
            found_in = 1'b1;
            hit_in = SW'(i);
         end
      end
   end

   logic [6:0] poff;
   logic [16:0] diff;
   logic [15:0] plen;
   logic [2:0] cs;
   logic [15:0] lp;
   logic mq, http;
   logic fin, syn, ack;
   logic [31:0] est_ack;
   assign poff = {1'b0, iphw, 2'b00} + {1'b0, tcpw, 2'b00};
   assign diff = {1'b0, tot} - {10'd0, poff};
   assign plen = diff[16] ? 16'd0 : diff[15:0];
   assign cs = cst_ff[hit_ff];
   assign lp = lport_ff[hit_ff];
   assign mq = (sport == mqr_ff) || (lp == mql_ff);
   assign http = (lp == http_ff);
   assign fin = (fl & tce_pkg::FL_FIN) != 8'd0;
   assign syn = (fl & tce_pkg::FL_SYN) != 8'd0;
   assign ack = (fl & tce_pkg::FL_ACK) != 8'd0;
   assign est_ack = rseq + {16'd0, plen} + {31'd0, fin};

   always_ff @(posedge clock) begin
      if (reset) begin
         http_ff <= tce_pkg::RST_HTTP_PORT;
         mqr_ff <= tce_pkg::RST_MQTT_REMOTE;
         mql_ff <= tce_pkg::RST_MQTT_LOCAL;
         iseq_ff <= tce_pkg::RST_SERVER_SEQ;
      end else if (csr_write) begin
         case (csr_index)
            tce_pkg::REG_HTTP_PORT: http_ff <= csr_data[15:0];
            tce_pkg::REG_MQTT_REMOTE: mqr_ff <= csr_data[15:0];
            tce_pkg::REG_MQTT_LOCAL: mql_ff <= csr_data[15:0];
            tce_pkg::REG_SERVER_SEQ: iseq_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= in_data;
      if (cmd.lookup) begin
         found_ff <= found_in;
         hit_ff <= hit_in;
      end
      if (cmd.load_out) begin
         out_ff <= {res_ff[cmd.out_idx].kind, res_ff[cmd.out_idx].flags,
                    o_seq_ff[cmd.out_idx], o_ack_ff[cmd.out_idx], slp_ff, srp_ff,
                    2'(hit_ff), res_ff[cmd.out_idx].event_code,
                    res_ff[cmd.out_idx].kind && res_ff[cmd.out_idx].event_code !=
                       tce_pkg::EV_MQTT_CONN ? plen_ff : 16'd0,
                    res_ff[cmd.out_idx].kind && res_ff[cmd.out_idx].event_code !=
                       tce_pkg::EV_MQTT_CONN ? poff_ff : 7'd0,
                    1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            act_ff[i] <= (i == 0);
            lport_ff[i] <= (i == 0) ? tce_pkg::RST_HTTP_PORT : 16'd0;
            rport_ff[i] <= 16'd0;
            cst_ff[i] <= (i == 0) ? tce_pkg::ST_LISTEN : tce_pkg::ST_CLOSED;
            sseq_ff[i] <= 32'd0;
            rack_ff[i] <= 32'd0;
         end
         cnt_ff <= 2'd0;
      end else if (cmd.execute) begin
         cnt_ff <= 2'd0;
         if (func) begin
            if (32'(oslot) < NUM_SLOTS) begin
               act_ff[SW'(oslot)] <= 1'b1;
               lport_ff[SW'(oslot)] <= dport;
               rport_ff[SW'(oslot)] <= sport;
               cst_ff[SW'(oslot)] <= omode ? tce_pkg::ST_SYN_SENT : tce_pkg::ST_LISTEN;
               sseq_ff[SW'(oslot)] <= rseq;
               rack_ff[SW'(oslot)] <= 32'd0;
            end
         end else if (found_ff) begin
            rport_ff[hit_ff] <= sport;
            slp_ff <= lp;
            srp_ff <= sport;
            plen_ff <= plen;
            poff_ff <= poff;
            case (cs)
               tce_pkg::ST_LISTEN: begin
                  if (syn) begin
                     sseq_ff[hit_ff] <= iseq_ff + 32'd1;
                     rack_ff[hit_ff] <= rseq + 32'd1;
                     cst_ff[hit_ff] <= tce_pkg::ST_SYN_RCVD;
                     res_ff[0] <= '{1'b0, tce_pkg::FL_SYNACK, tce_pkg::EV_NONE};
                     o_seq_ff[0] <= iseq_ff;
                     o_ack_ff[0] <= rseq + 32'd1;
                     cnt_ff <= 2'd1;
                  end
               end
               tce_pkg::ST_SYN_SENT: begin
                  if ((fl & tce_pkg::FL_SYNACK) == tce_pkg::FL_SYNACK) begin
                     sseq_ff[hit_ff] <= rack;
                     rack_ff[hit_ff] <= rseq + 32'd1;
                     cst_ff[hit_ff] <= tce_pkg::ST_ESTAB;
                     res_ff[0] <= '{1'b0, tce_pkg::FL_ACK, tce_pkg::EV_NONE};
                     o_seq_ff[0] <= rack;
                     o_ack_ff[0] <= rseq + 32'd1;
                     res_ff[1] <= '{1'b1, 8'd0, tce_pkg::EV_MQTT_CONN};
                     o_seq_ff[1] <= 32'd0;
                     o_ack_ff[1] <= 32'd0;
                     cnt_ff <= mq ? 2'd2 : 2'd1;
                  end
               end
               tce_pkg::ST_SYN_RCVD: begin
                  if (ack && !syn) cst_ff[hit_ff] <= tce_pkg::ST_ESTAB;
               end
               tce_pkg::ST_ESTAB: begin
                  logic [1:0] n;
                  n = 2'd0;
                  rack_ff[hit_ff] <= est_ack;
                  sseq_ff[hit_ff] <= fin ? rack + 32'd1 : rack;
                  if (plen != 16'd0 && http) begin
                     res_ff[0] <= '{1'b1, 8'd0, tce_pkg::EV_HTTP};
                     o_seq_ff[0] <= 32'd0;
                     o_ack_ff[0] <= 32'd0;
                     n = 2'd1;
                  end else if (plen != 16'd0 && mq) begin
                     res_ff[0] <= '{1'b1, 8'd0, tce_pkg::EV_MQTT};
                     o_seq_ff[0] <= 32'd0;
                     o_ack_ff[0] <= 32'd0;
                     res_ff[1] <= '{1'b0, tce_pkg::FL_ACK, tce_pkg::EV_NONE};
                     o_seq_ff[1] <= rack;
                     o_ack_ff[1] <= est_ack;
                     n = 2'd2;
                  end
                  if (fin) begin
                     res_ff[n] <= '{1'b0, tce_pkg::FL_FINACK, tce_pkg::EV_NONE};
                     o_seq_ff[n] <= rack;
                     o_ack_ff[n] <= est_ack;
                     cst_ff[hit_ff] <= http ? tce_pkg::ST_LISTEN : tce_pkg::ST_CLOSED;
                     n = n + 2'd1;
                  end
                  cnt_ff <= n;
               end
               default: ;
            endcase
         end
      end
   end

   assign status.is_open = func;
   assign status.found = found_ff;
   assign status.count = cnt_ff;
   assign out_data = out_ff;
endmodule
